// ===== rtl/ccpg_pkg.sv =====
package ccpg_pkg;

  localparam int unsigned FONT_DEPTH  = 16384;
  localparam int unsigned FONT_AW     = 14;
  localparam int unsigned FONT_DW     = 8;
  localparam int unsigned PIX_PER_ROW = 8;
  localparam int unsigned PIX_BITS    = 4;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DW      = 5;

  localparam logic       CMD_RENDER     = 1'b0;
  localparam logic       CMD_FONT_WRITE = 1'b1;
  localparam logic [2:0] COLOUR_DEFAULT = 3'b111;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_COUNT     = 3'd0,
    CFG_OFFSET_LINE    = 3'd1,
    CFG_ATTR_FROM_NEXT = 3'd2,
    CFG_USE_RVV        = 3'd3,
    CFG_DASHED_LTEN    = 3'd4,
    CFG_FONT_SET       = 3'd5
  } cfg_reg_e;

  localparam int unsigned ATTR_HGLT = 0;
  localparam int unsigned ATTR_GPA  = 1;
  localparam int unsigned ATTR_RVV  = 2;
  localparam int unsigned ATTR_LTEN = 3;

  typedef struct packed {
    logic                command;
    logic [6:0]          char_code;
    logic [3:0]          line_index;
    logic                vsp;
    logic                lten;
    logic                hglt;
    logic                gpa0;
    logic                gpa1;
    logic                rvv;
    logic                last_in_line;
    logic [FONT_AW-1:0]  font_addr;
    logic [FONT_DW-1:0]  font_data;
  } in_t;

  typedef struct packed {
    logic [PIX_PER_ROW*PIX_BITS-1:0] pixels;
    logic                            line_end;
  } out_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic [3:0] line_index;
    logic       vsp;
    logic       lten;
    logic       hglt;
    logic       gpa0;
    logic       gpa1;
    logic       rvv;
  } cell_t;

  typedef struct packed {
    logic [3:0] attr_from_next;
    logic       use_rvv;
    logic       dashed_lten;
  } ctrl_t;

endpackage

// ===== rtl/char_cell_pixel_generator_unit.sv =====
// Character cell pixel generator. Render cells and font writes enter on the
// in channel, one per cycle while in_ready_o is high. A render cell is held
// until the next cell of the line arrives, so its pixels leave one cell
// late; the last cell of a line flushes the held cell and then its own
// pixels with line_end set. A render transfer is registered into the render
// stage with its font bytes; results leave through the output register, one
// per cycle while out_ready_i allows, so a last cell that follows a held cell
// stays in the render stage until both results have left, the held one first.
// The font is kept twice, one copy for the held cell and one for the
// arriving cell, so both bytes are read in the same cycle. Font entries are
// undefined until written.
module char_cell_pixel_generator_unit #(
  parameter int unsigned FONT_SETS   = 8,
  parameter int unsigned CHAR_HEIGHT = 16,
  parameter int unsigned SET_BYTES   = 2048
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  ccpg_pkg::in_t                      in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output ccpg_pkg::out_t                     out_data_o,
  input  logic                               cfg_we_i,
  input  logic [ccpg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ccpg_pkg::CFG_DW-1:0]        cfg_wdata_i
);

  localparam logic [3:0] SETS = 4'(FONT_SETS);

  function automatic logic [ccpg_pkg::FONT_AW-1:0] font_index(
    input ccpg_pkg::cell_t c,
    input logic [3:0]      set_mod,
    input logic            offset_mode,
    input logic [4:0]      line_count
  );
    logic [3:0]  fl;
    logic [4:0]  lc_m1;
    logic [31:0] sum;
    lc_m1 = line_count - 5'd1;
    if (offset_mode) begin
      fl = (c.line_index != 4'd0) ? c.line_index - 4'd1 : lc_m1[3:0];
    end else begin
      fl = c.line_index;
    end
    sum = 32'(set_mod) * 32'(SET_BYTES) + 32'(c.char_code) * 32'(CHAR_HEIGHT)
        + 32'(fl);
    return sum[ccpg_pkg::FONT_AW-1:0];
  endfunction

  // configuration
  logic [4:0] line_cnt_q, line_cnt_d;
  logic       ofs_mode_q, ofs_mode_d;
  logic [3:0] attr_next_q, attr_next_d;
  logic       use_rvv_q, use_rvv_d;
  logic       dashed_q, dashed_d;
  logic [2:0] font_set_q, font_set_d;
  logic [3:0] set_mod;
  ccpg_pkg::ctrl_t ctrl;

  // intake and hold
  logic            acc_in, acc_render, acc_write;
  ccpg_pkg::cell_t in_cell;
  logic            held_valid_q, held_valid_d;
  ccpg_pkg::cell_t held_cell_q, held_cell_d;
  logic [ccpg_pkg::FONT_AW-1:0] held_idx, cur_idx;
  logic [ccpg_pkg::FONT_DW-1:0] held_byte, cur_byte;

  // render stage
  logic            b_valid_q, b_valid_d;
  logic            b_phase_q, b_phase_d;
  logic            b_held_v_q, b_held_v_d;
  logic            b_last_q, b_last_d;
  ccpg_pkg::cell_t b_held_q, b_held_d;
  ccpg_pkg::cell_t b_cell_q, b_cell_d;
  logic            flag_q, flag_d;
  logic            has_result, sel_held, out_load, emit, cur_final, b_done;
  ccpg_pkg::cell_t r_cell;
  logic [ccpg_pkg::FONT_DW-1:0] r_byte;
  logic [ccpg_pkg::PIX_PER_ROW*ccpg_pkg::PIX_BITS-1:0] r_pixels;
  logic            r_flag;

  // output register
  logic            out_valid_q, out_valid_d;
  ccpg_pkg::out_t  out_data_q, out_data_d;

  always_comb begin
    line_cnt_d  = line_cnt_q;
    ofs_mode_d  = ofs_mode_q;
    attr_next_d = attr_next_q;
    use_rvv_d   = use_rvv_q;
    dashed_d    = dashed_q;
    font_set_d  = font_set_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        ccpg_pkg::CFG_LINE_COUNT:     line_cnt_d  = cfg_wdata_i;
        ccpg_pkg::CFG_OFFSET_LINE:    ofs_mode_d  = cfg_wdata_i[0];
        ccpg_pkg::CFG_ATTR_FROM_NEXT: attr_next_d = cfg_wdata_i[3:0];
        ccpg_pkg::CFG_USE_RVV:        use_rvv_d   = cfg_wdata_i[0];
        ccpg_pkg::CFG_DASHED_LTEN:    dashed_d    = cfg_wdata_i[0];
        ccpg_pkg::CFG_FONT_SET:       font_set_d  = cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    set_mod = {1'b0, font_set_q};
    for (int i = 0; i < 8; i++) begin
      if (set_mod >= SETS) begin
        set_mod = set_mod - SETS;
      end
    end
  end

  assign ctrl = '{attr_from_next: attr_next_q, use_rvv: use_rvv_q, dashed_lten: dashed_q};

  assign in_cell = '{
    char_code:  in_data_i.char_code,
    line_index: in_data_i.line_index,
    vsp:        in_data_i.vsp,
    lten:       in_data_i.lten,
    hglt:       in_data_i.hglt,
    gpa0:       in_data_i.gpa0,
    gpa1:       in_data_i.gpa1,
    rvv:        in_data_i.rvv
  };

  assign acc_in     = in_valid_i && in_ready_o;
  assign acc_write  = acc_in && (in_data_i.command == ccpg_pkg::CMD_FONT_WRITE);
  assign acc_render = acc_in && (in_data_i.command == ccpg_pkg::CMD_RENDER);

  assign held_idx = font_index(held_cell_q, set_mod, ofs_mode_q, line_cnt_q);
  assign cur_idx  = font_index(in_cell, set_mod, ofs_mode_q, line_cnt_q);

  ccpg_ram #(
    .WIDTH(ccpg_pkg::FONT_DW),
    .DEPTH(ccpg_pkg::FONT_DEPTH)
  ) u_ram_held (
    .clk_i  (clk_i),
    .we_i   (acc_write),
    .waddr_i(in_data_i.font_addr),
    .wdata_i(in_data_i.font_data),
    .re_i   (acc_render),
    .raddr_i(held_idx),
    .rdata_o(held_byte)
  );

  ccpg_ram #(
    .WIDTH(ccpg_pkg::FONT_DW),
    .DEPTH(ccpg_pkg::FONT_DEPTH)
  ) u_ram_cur (
    .clk_i  (clk_i),
    .we_i   (acc_write),
    .waddr_i(in_data_i.font_addr),
    .wdata_i(in_data_i.font_data),
    .re_i   (acc_render),
    .raddr_i(cur_idx),
    .rdata_o(cur_byte)
  );

  always_comb begin
    held_valid_d = held_valid_q;
    held_cell_d  = held_cell_q;
    if (acc_render) begin
      held_valid_d = !in_data_i.last_in_line;
      held_cell_d  = in_cell;
    end
  end

  assign has_result = b_held_v_q || b_last_q;
  assign sel_held   = b_held_v_q && !b_phase_q;
  assign r_cell     = sel_held ? b_held_q : b_cell_q;
  assign r_byte     = sel_held ? held_byte : cur_byte;
  assign out_load   = !out_valid_q || out_ready_i;
  assign emit       = b_valid_q && has_result && out_load;
  assign cur_final  = !sel_held || !b_last_q;
  assign b_done     = b_valid_q && (!has_result || (emit && cur_final));
  assign in_ready_o = !b_valid_q || b_done;

  ccpg_render u_render (
    .cell_i     (r_cell),
    .next_i     (b_cell_q),
    .font_byte_i(r_byte),
    .flag_i     (flag_q),
    .ctrl_i     (ctrl),
    .pixels_o   (r_pixels),
    .flag_o     (r_flag)
  );

  always_comb begin
    b_valid_d  = b_valid_q;
    b_phase_d  = b_phase_q;
    b_held_v_d = b_held_v_q;
    b_last_d   = b_last_q;
    b_held_d   = b_held_q;
    b_cell_d   = b_cell_q;
    if (b_done) begin
      b_valid_d = 1'b0;
      b_phase_d = 1'b0;
    end else if (emit && sel_held) begin
      b_phase_d = 1'b1;
    end
    if (acc_render) begin
      b_valid_d  = 1'b1;
      b_held_v_d = held_valid_q;
      b_last_d   = in_data_i.last_in_line;
      b_held_d   = held_cell_q;
      b_cell_d   = in_cell;
    end
  end

  // flag clears after the line end result
  assign flag_d = emit ? (sel_held ? r_flag : 1'b0) : flag_q;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (emit) begin
      out_valid_d         = 1'b1;
      out_data_d.pixels   = r_pixels;
      out_data_d.line_end = !sel_held;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_cnt_q   <= 5'd10;
      ofs_mode_q   <= 1'b0;
      attr_next_q  <= 4'd0;
      use_rvv_q    <= 1'b0;
      dashed_q     <= 1'b1;
      font_set_q   <= 3'd0;
      held_valid_q <= 1'b0;
      b_valid_q    <= 1'b0;
      b_phase_q    <= 1'b0;
      b_held_v_q   <= 1'b0;
      b_last_q     <= 1'b0;
      flag_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      line_cnt_q   <= line_cnt_d;
      ofs_mode_q   <= ofs_mode_d;
      attr_next_q  <= attr_next_d;
      use_rvv_q    <= use_rvv_d;
      dashed_q     <= dashed_d;
      font_set_q   <= font_set_d;
      held_valid_q <= held_valid_d;
      b_valid_q    <= b_valid_d;
      b_phase_q    <= b_phase_d;
      b_held_v_q   <= b_held_v_d;
      b_last_q     <= b_last_d;
      flag_q       <= flag_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_cell_q <= held_cell_d;
    b_held_q    <= b_held_d;
    b_cell_q    <= b_cell_d;
    out_data_q  <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_phase_needs_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_phase_q |-> (b_valid_q && b_held_v_q && b_last_q))
    else $error("second result pending without a held cell and a line end");

  a_render_enters_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_render |=> b_valid_q)
    else $error("render transfer did not reach the render stage");

  a_last_clears_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_render && in_data_i.last_in_line) |=> !held_valid_q)
    else $error("held cell survived a line end");

  a_line_end_clears_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !sel_held) |=> (!flag_q && out_valid_q && out_data_q.line_end))
    else $error("line end result did not clear the underline flag");

endmodule

// ===== rtl/ccpg_ram.sv =====
module ccpg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/ccpg_render.sv =====
module ccpg_render (
  input  ccpg_pkg::cell_t                                         cell_i,
  input  ccpg_pkg::cell_t                                         next_i,
  input  logic [ccpg_pkg::FONT_DW-1:0]                            font_byte_i,
  input  logic                                                    flag_i,
  input  ccpg_pkg::ctrl_t                                         ctrl_i,
  output logic [ccpg_pkg::PIX_PER_ROW*ccpg_pkg::PIX_BITS-1:0]     pixels_o,
  output logic                                                    flag_o
);

  logic       hg, g0, g1, rv, lt, f;
  logic [2:0] colour;
  logic [ccpg_pkg::PIX_PER_ROW-1:0] lit;

  always_comb begin
    hg = ctrl_i.attr_from_next[ccpg_pkg::ATTR_HGLT] ? next_i.hglt : cell_i.hglt;
    g0 = ctrl_i.attr_from_next[ccpg_pkg::ATTR_GPA]  ? next_i.gpa0 : cell_i.gpa0;
    g1 = ctrl_i.attr_from_next[ccpg_pkg::ATTR_GPA]  ? next_i.gpa1 : cell_i.gpa1;
    rv = ctrl_i.attr_from_next[ccpg_pkg::ATTR_RVV]  ? next_i.rvv  : cell_i.rvv;
    lt = ctrl_i.attr_from_next[ccpg_pkg::ATTR_LTEN] ? next_i.lten : cell_i.lten;
    colour = {hg, g0, g1};
    if (colour == 3'b000) begin
      colour = ccpg_pkg::COLOUR_DEFAULT;
    end
    f = ctrl_i.dashed_lten ? (lt && !flag_i) : lt;
    for (int i = 0; i < int'(ccpg_pkg::PIX_PER_ROW); i++) begin
      lit[i] = f || !(cell_i.vsp || font_byte_i[ccpg_pkg::PIX_PER_ROW-1-i]);
      if (rv && ctrl_i.use_rvv) begin
        lit[i] = !lit[i];
      end
      pixels_o[i*ccpg_pkg::PIX_BITS +: ccpg_pkg::PIX_BITS] =
        lit[i] ? {1'b0, colour} : '0;
    end
    // dashed mode: the flag sets on an underlined cell or when font bit 2 (column 5) would light
    flag_o = ctrl_i.dashed_lten ? (f || !(cell_i.vsp || font_byte_i[2])) : f;
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  ccpg_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ccpg_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [ccpg_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [ccpg_pkg::CFG_DW-1:0] cfg_wdata = '0;

  char_cell_pixel_generator_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // settings as the block sees them
  logic [4:0] rows_per_char = 5'd10;
  logic offset_mode = 1'b0;
  logic [3:0] borrow_mask = 4'd0;
  logic reverse_on = 1'b0;
  logic dashed_on = 1'b1;
  logic [2:0] glyph_set = 3'd0;

  // predicted font contents and line state
  logic [7:0] glyph_mem [ccpg_pkg::FONT_DEPTH];
  ccpg_pkg::cell_t held_glyph = '0;
  logic held_present = 1'b0;
  logic underline_on = 1'b0;
  ccpg_pkg::out_t expected_rows [$];

  // font entries already written by queued transfers
  bit font_loaded [ccpg_pkg::FONT_DEPTH];
  ccpg_pkg::in_t pending_items [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req_id = 0;
  int hold_seen_id = 0;
  int hold_left = 0;
  int mismatches = 0;
  ccpg_pkg::out_t want;

  function automatic logic [ccpg_pkg::FONT_AW-1:0] font_index(logic [6:0] code,
                                                              logic [3:0] row);
    logic [3:0] glyph_row;
    if (offset_mode && row == 4'd0) begin
      glyph_row = 4'(rows_per_char - 5'd1);
    end else if (offset_mode) begin
      glyph_row = row - 4'd1;
    end else begin
      glyph_row = row;
    end
    return {glyph_set, code, glyph_row};
  endfunction

  function automatic logic [31:0] shade_glyph(ccpg_pkg::cell_t c, ccpg_pkg::cell_t nx);
    logic hg, g0, g1, rv, lt, lit, ul;
    logic [2:0] colour;
    logic [7:0] glyph;
    logic [31:0] pix;
    hg = borrow_mask[ccpg_pkg::ATTR_HGLT] ? nx.hglt : c.hglt;
    g0 = borrow_mask[ccpg_pkg::ATTR_GPA] ? nx.gpa0 : c.gpa0;
    g1 = borrow_mask[ccpg_pkg::ATTR_GPA] ? nx.gpa1 : c.gpa1;
    rv = borrow_mask[ccpg_pkg::ATTR_RVV] ? nx.rvv : c.rvv;
    lt = borrow_mask[ccpg_pkg::ATTR_LTEN] ? nx.lten : c.lten;
    colour = {hg, g0, g1};
    if (colour == 3'd0) begin
      colour = ccpg_pkg::COLOUR_DEFAULT;
    end
    glyph = glyph_mem[font_index(c.char_code, c.line_index)];
    ul = dashed_on ? (lt && !underline_on) : lt;
    pix = '0;
    for (int px = 0; px < ccpg_pkg::PIX_PER_ROW; px++) begin
      lit = ul || !(c.vsp || glyph[7-px]);
      if (rv && reverse_on) begin
        lit = !lit;
      end
      if (lit) begin
        pix[ccpg_pkg::PIX_BITS*px +: ccpg_pkg::PIX_BITS] = {1'b0, colour};
      end
    end
    if (dashed_on && (ul || !(c.vsp || glyph[2]))) begin
      ul = 1'b1;
    end
    underline_on = ul;
    return pix;
  endfunction

  function automatic void predict_rows(ccpg_pkg::in_t it);
    ccpg_pkg::cell_t c;
    ccpg_pkg::out_t r;
    if (it.command == ccpg_pkg::CMD_FONT_WRITE) begin
      glyph_mem[it.font_addr] = it.font_data;
      return;
    end
    c = {it.char_code, it.line_index, it.vsp, it.lten, it.hglt, it.gpa0, it.gpa1, it.rvv};
    if (held_present) begin
      r.pixels = shade_glyph(held_glyph, c);
      r.line_end = 1'b0;
      expected_rows.push_back(r);
    end
    if (it.last_in_line) begin
      r.pixels = shade_glyph(c, c);
      r.line_end = 1'b1;
      expected_rows.push_back(r);
      held_present = 1'b0;
      underline_on = 1'b0;
      held_glyph = '0;
    end else begin
      held_glyph = c;
      held_present = 1'b1;
    end
  endfunction

  function automatic ccpg_pkg::in_t noise_item();
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    return ccpg_pkg::in_t'(noise[$bits(ccpg_pkg::in_t)-1:0]);
  endfunction

  function automatic int queue_font(logic [ccpg_pkg::FONT_AW-1:0] addr, logic [7:0] data);
    ccpg_pkg::in_t it;
    it = noise_item();
    it.command = ccpg_pkg::CMD_FONT_WRITE;
    it.font_addr = addr;
    it.font_data = data;
    font_loaded[addr] = 1'b1;
    pending_items.push_back(it);
    return 1;
  endfunction

  // attrs: {vsp, lten, hglt, gpa0, gpa1, rvv}
  function automatic int queue_glyph(logic [6:0] code, logic [3:0] row, logic [5:0] attrs,
                                     logic last);
    ccpg_pkg::in_t it;
    logic [ccpg_pkg::FONT_AW-1:0] idx;
    int n;
    n = 0;
    idx = font_index(code, row);
    if (!font_loaded[idx]) begin
      n += queue_font(idx, 8'($urandom));
    end
    it = noise_item();
    it.command = ccpg_pkg::CMD_RENDER;
    it.char_code = code;
    it.line_index = row;
    {it.vsp, it.lten, it.hglt, it.gpa0, it.gpa1, it.rvv} = attrs;
    it.last_in_line = last;
    pending_items.push_back(it);
    return n + 1;
  endfunction

  function automatic void queue_scan_lines(int budget);
    int n, len;
    logic [3:0] row;
    logic [6:0] code;
    n = 0;
    while (n < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        n += queue_font(14'($urandom), 8'($urandom));
      end else begin
        len = $urandom_range(1, 12);
        row = 4'($urandom);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 3) == 0) begin
            code = 7'($urandom);
          end else begin
            code = {$urandom_range(0, 1) ? 5'h1F : 5'h00, 2'($urandom)};
          end
          if ($urandom_range(0, 3) == 0) begin
            row = 4'($urandom);
          end
          n += queue_glyph(code, row, 6'($urandom), k == len - 1);
        end
      end
    end
  endfunction

  task automatic load_settings(logic [4:0] lc, logic olm, logic [3:0] afn, logic rvv,
                               logic dash, logic [2:0] fs);
    ccpg_pkg::cfg_reg_e regs [6];
    logic [4:0] vals [6];
    regs = '{ccpg_pkg::CFG_LINE_COUNT, ccpg_pkg::CFG_OFFSET_LINE,
             ccpg_pkg::CFG_ATTR_FROM_NEXT, ccpg_pkg::CFG_USE_RVV,
             ccpg_pkg::CFG_DASHED_LTEN, ccpg_pkg::CFG_FONT_SET};
    vals = '{lc, 5'(olm), 5'(afn), 5'(rvv), 5'(dash), 5'(fs)};
    for (int r = 0; r < 6; r++) begin
      @(posedge clk_i);
      cfg_we <= 1'b1;
      cfg_idx <= regs[r];
      cfg_wdata <= vals[r];
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
    rows_per_char = lc;
    offset_mode = olm;
    borrow_mask = afn;
    reverse_on = rvv;
    dashed_on = dash;
    glyph_set = fs;
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_rows.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_phase(int budget, int tx_idle, int rx_stall, bit pressure);
    @(negedge clk_i);
    send_idle_pct = tx_idle;
    recv_stall_pct = rx_stall;
    if (pressure) begin
      hold_req_id++;
    end
    queue_scan_lines(budget);
    wait_drained();
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // sender
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_rows(in_data);
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rows.size() == 0) begin
          $error("result transfer with nothing expected: pixels %h line_end %b",
                 out_data.pixels, out_data.line_end);
          mismatches++;
        end else begin
          want = expected_rows.pop_front();
          if (out_data.pixels !== want.pixels) begin
            $error("pixels: expected %h, got %h", want.pixels, out_data.pixels);
            mismatches++;
          end
          if (out_data.line_end !== want.line_end) begin
            $error("line_end: expected %b, got %b", want.line_end, out_data.line_end);
            mismatches++;
          end
        end
      end
      if (hold_req_id != hold_seen_id) begin
        hold_seen_id <= hold_req_id;
        hold_left <= 300;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(1, 100) > recv_stall_pct);
      end
    end
  end

  initial begin
    int n;
    int tx_modes [4];
    int rx_modes [4];
    tx_modes = '{0, 83, 0, 9};
    rx_modes = '{0, 0, 83, 9};
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;

    // reset settings: plain font lines, dashed underline on
    @(negedge clk_i);
    n = queue_font(14'h0000, 8'h00);
    n = queue_font(14'h07FF, 8'hFF);
    n = queue_font(14'h3FFF, 8'hFF);
    n = queue_font(14'h0010, 8'h04);
    n = queue_font(14'h0020, 8'hFB);
    n = queue_glyph(7'd0, 4'd0, 6'b000000, 1'b0);
    n = queue_glyph(7'd127, 4'd15, 6'b111111, 1'b0);
    n = queue_glyph(7'd1, 4'd0, 6'b010000, 1'b0);
    n = queue_glyph(7'd1, 4'd0, 6'b010000, 1'b0);
    n = queue_glyph(7'd2, 4'd0, 6'b010000, 1'b1);
    n = queue_glyph(7'd0, 4'd0, 6'b000000, 1'b1);
    n = queue_glyph(7'd127, 4'd15, 6'b100000, 1'b1);
    n = queue_glyph(7'd1, 4'd0, 6'b001110, 1'b0);
    n = queue_glyph(7'd2, 4'd0, 6'b000101, 1'b0);
    n = queue_glyph(7'd0, 4'd0, 6'b000011, 1'b1);
    n = queue_glyph(7'd127, 4'd15, 6'b011111, 1'b0);
    n = queue_glyph(7'd0, 4'd0, 6'b100001, 1'b1);
    wait_drained();

    load_settings(5'd1, 1'b1, 4'hF, 1'b1, 1'b1, 3'd0);
    run_phase(125, tx_modes[0], rx_modes[0], 1'b0);
    load_settings(5'd16, 1'b1, 4'h0, 1'b0, 1'b0, 3'd7);
    run_phase(125, tx_modes[1], rx_modes[1], 1'b0);
    load_settings(5'd0, 1'b1, 4'h5, 1'b1, 1'b1, 3'd3);
    run_phase(125, tx_modes[2], rx_modes[2], 1'b0);
    load_settings(5'd31, 1'b0, 4'hA, 1'b1, 1'b0, 3'd1);
    run_phase(125, tx_modes[3], rx_modes[3], 1'b0);
    load_settings(5'($urandom), 1'($urandom), 4'($urandom), 1'b1, 1'($urandom), 3'($urandom));
    run_phase(125, 0, 0, 1'b1);
    for (int p = 0; p < 4; p++) begin
      load_settings(5'($urandom), 1'($urandom), 4'($urandom), 1'($urandom), 1'($urandom),
                    3'($urandom));
      run_phase(100, tx_modes[p], rx_modes[p], 1'b0);
    end

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
